// ===== hw/rtl/lbpu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpu_pkg
// Shared types and constants of the lossless bitmap pixel unpacker.
// ----------------------------------------------------------------------------
package lbpu_pkg;

  // Color table geometry
  localparam int TableDepth = 256;
  localparam int TableAw    = $clog2(TableDepth);
  localparam int FillW      = 9;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;

  // Pixel formats
  typedef enum logic [1:0] {
    FmtPalette = 2'd0,
    FmtRgb555  = 2'd1,
    FmtXrgb32  = 2'd2
  } fmt_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgFormat  = 3'd0,
    CfgAlpha   = 3'd1,
    CfgWidth   = 3'd2,
    CfgHeight  = 3'd3,
    CfgEntries = 3'd4
  } cfg_idx_e;

  // Per-byte decision handed from the stream control to the pixel pipeline
  typedef struct packed {
    logic               emit;
    logic               last;
    logic               use_table;
    logic               hit;
    logic [31:0]        pixel;
    logic               tbl_we;
    logic [TableAw-1:0] tbl_waddr;
    logic [31:0]        tbl_wdata;
  } ctrl_res_t;

endpackage

// ===== hw/rtl/lbpu_stream_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpu_stream_ctrl
// Configuration registers, byte gathering, palette fill count and the
// column/row counters. Decides per accepted byte what the pipeline emits.
// ----------------------------------------------------------------------------
module lbpu_stream_ctrl import lbpu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  output ctrl_res_t           res_o
);

  logic [1:0]       fmt_q;
  logic             alpha_q;
  logic [15:0]      width_q;
  logic [15:0]      height_q;
  logic [FillW-1:0] entries_q;

  logic [23:0]      gather_q, gather_d;
  logic [1:0]       phase_q, phase_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [15:0]      col_q, col_d;
  logic [15:0]      row_q, row_d;

  logic [15:0]      w_eff, h_eff;
  logic [FillW-1:0] entries_eff;
  logic [16:0]      units;
  logic [31:0]      px;
  logic             adv;
  logic             is_last;
  logic [15:0]      c555;
  logic [1:0]       need_m1;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q     <= FmtPalette;
      alpha_q   <= 1'b0;
      width_q   <= 16'd1;
      height_q  <= 16'd1;
      entries_q <= FillW'(TableDepth);
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgFormat:  fmt_q     <= cfg_data_i[1:0];
        CfgAlpha:   alpha_q   <= cfg_data_i[0];
        CfgWidth:   width_q   <= cfg_data_i;
        CfgHeight:  height_q  <= cfg_data_i;
        CfgEntries: entries_q <= cfg_data_i[FillW-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry: zero counts as one, palette size saturates
  assign w_eff       = (width_q == 16'd0) ? 16'd1 : width_q;
  assign h_eff       = (height_q == 16'd0) ? 16'd1 : height_q;
  assign entries_eff = (entries_q > FillW'(TableDepth)) ? FillW'(TableDepth) : entries_q;
  assign c555        = {gather_q[7:0], data_byte_i};
  assign need_m1     = alpha_q ? 2'd3 : 2'd2;
  assign is_last     = (col_q >= w_eff - 16'd1) && (row_q >= h_eff - 16'd1);

  // Byte decode and counter advance
  always_comb begin
    res_o    = '0;
    gather_d = gather_q;
    phase_d  = phase_q;
    fill_d   = fill_q;
    col_d    = col_q;
    row_d    = row_q;
    adv      = 1'b0;
    units    = '0;
    px       = '0;

    res_o.tbl_waddr = fill_q[TableAw-1:0];

    case (fmt_e'(fmt_q))
      FmtPalette: begin
        if (fill_q < entries_eff) begin
          // Loading a color entry
          if (phase_q >= need_m1) begin
            res_o.tbl_we    = 1'b1;
            res_o.tbl_wdata = alpha_q ? {data_byte_i, gather_q}
                                      : {8'hFF, gather_q[15:0], data_byte_i};
            fill_d   = fill_q + FillW'(1);
            gather_d = '0;
            phase_d  = '0;
          end else begin
            gather_d = {gather_q[15:0], data_byte_i};
            phase_d  = phase_q + 2'd1;
          end
        end else begin
          // Index byte; rows padded to a multiple of four bytes
          adv             = 1'b1;
          units           = ({1'b0, w_eff} + 17'd3) & ~17'd3;
          res_o.use_table = 1'b1;
          res_o.hit       = ({1'b0, data_byte_i} < fill_q) &&
                            ({1'b0, data_byte_i} < FillW'(TableDepth));
        end
      end
      FmtRgb555: begin
        if (phase_q == 2'd0) begin
          gather_d = {16'd0, data_byte_i};
          phase_d  = 2'd1;
        end else begin
          gather_d = '0;
          phase_d  = '0;
          adv      = 1'b1;
          units    = {1'b0, w_eff} + {16'd0, w_eff[0]};
          px       = {8'hFF, c555[14:10], c555[14:12], c555[9:5], c555[9:7],
                      c555[4:0], c555[4:2]};
        end
      end
      FmtXrgb32: begin
        if (phase_q != 2'd3) begin
          gather_d = {gather_q[15:0], data_byte_i};
          phase_d  = phase_q + 2'd1;
        end else begin
          gather_d = '0;
          phase_d  = '0;
          adv      = 1'b1;
          units    = {1'b0, w_eff};
          px       = {gather_q, data_byte_i};
        end
      end
      default: ;
    endcase

    if (adv) begin
      if (col_q < w_eff) begin
        res_o.emit  = 1'b1;
        res_o.last  = is_last;
        res_o.pixel = px;
      end
      if ((col_q < w_eff) && is_last) begin
        // Image done: restart all stream counters for the next one
        gather_d = '0;
        phase_d  = '0;
        fill_d   = '0;
        col_d    = '0;
        row_d    = '0;
      end else if (({1'b0, col_q} + 17'd1) >= units) begin
        col_d = '0;
        row_d = row_q + 16'd1;
      end else begin
        col_d = col_q + 16'd1;
      end
    end
  end

  // Stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gather_q <= '0;
      phase_q  <= '0;
      fill_q   <= '0;
      col_q    <= '0;
      row_q    <= '0;
    end else if (accept_i) begin
      gather_q <= gather_d;
      phase_q  <= phase_d;
      fill_q   <= fill_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  // Checks
  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res_o.emit && res_o.last |=> col_q == 16'd0 && row_q == 16'd0 &&
                                            fill_q == '0 && phase_q == '0)
    else $error("counters not cleared after last pixel");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.tbl_we |-> fill_q < FillW'(TableDepth) && !res_o.emit)
    else $error("table write beyond depth or with a pixel");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res_o.tbl_we |=> fill_q == $past(fill_q) + FillW'(1))
    else $error("fill count did not step on table write");

endmodule

// ===== hw/rtl/lossless_bitmap_pixel_unpacker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lossless_bitmap_pixel_unpacker
// Turns an inflated lossless bitmap byte stream (palette, RGB555 or XRGB32)
// into ARGB32 pixels with a last-pixel flag.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while in_stall_o is low; a pixel leaves after 1, 2 or 4 bytes.
// Pipeline: from byte accept a pixel passes the color table read register
//   (read stage), then the output register.
// Two result slots (read stage and output register) keep input flowing
//   while one pixel waits at the output.
// Reset: async active low; counters and config return to defaults. The
//   color table is not cleared; the fill count masks unloaded entries.
// ----------------------------------------------------------------------------
module lossless_bitmap_pixel_unpacker import lbpu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Byte input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  // Pixel output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [31:0]         pixel_argb_o,
  output logic                last_pixel_o
);

  ctrl_res_t   res;
  logic        in_accept;
  logic        s1_move;

  logic        s1_valid_q;
  logic        s1_last_q;
  logic        s1_use_table_q;
  logic        s1_hit_q;
  logic [31:0] s1_pixel_q;
  logic [31:0] rdata_q;
  logic [31:0] s1_argb;

  logic        out_valid_q;
  logic        out_last_q;
  logic [31:0] out_pixel_q;

  logic [31:0] color_mem [TableDepth];

  assign cfg_ready_o = 1'b1;
  assign s1_move     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !s1_move;
  assign in_accept   = in_valid_i && !in_stall_o;

  lbpu_stream_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (in_accept),
    .data_byte_i (data_byte_i),
    .res_o       (res)
  );

  // Color table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (in_accept && res.tbl_we) begin
      color_mem[res.tbl_waddr] <= res.tbl_wdata;
    end
    if (in_accept) begin
      rdata_q <= color_mem[data_byte_i[TableAw-1:0]];
    end
  end

  // Read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= res.emit;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_last_q      <= res.last;
      s1_use_table_q <= res.use_table;
      s1_hit_q       <= res.hit;
      s1_pixel_q     <= res.pixel;
    end
  end

  // Unloaded palette entries read as zero
  assign s1_argb = s1_use_table_q ? (s1_hit_q ? rdata_q : 32'd0) : s1_pixel_q;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_pixel_q <= s1_argb;
      out_last_q  <= s1_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_argb_o = out_pixel_q;
  assign last_pixel_o = out_last_q;

  // Checks
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with a free slot");

  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_q && out_pixel_q == $past(s1_argb))
    else $error("read stage result lost");

  a_no_result_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !res.emit |=> !s1_valid_q)
    else $error("result invented for a byte without pixel");

endmodule

// ===== tb/tb_lossless_bitmap_pixel_unpacker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lossless_bitmap_pixel_unpacker
// Self-checking bench for the bitmap pixel unpacker. Feeds palette, RGB555
// and XRGB32 byte streams under random idle gaps and output stalls. An
// in-bench unpacker predicts every ARGB pixel and last flag, and each pixel
// that leaves the block is compared in order against those predictions.
// ----------------------------------------------------------------------------
module tb_lossless_bitmap_pixel_unpacker;
  import lbpu_pkg::*;

  localparam logic [1:0] FmtReserved = 2'd3;
  localparam int RandomBytes = 1850;
  localparam int CycleLimit  = 1_000_000;
  localparam int DrainCycles = 8;

  typedef struct packed {
    logic [31:0] argb;
    logic        last;
  } pixel_t;

  // DUT ports
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgFormat;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [7:0]          data_byte_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [31:0]         pixel_argb_o;
  logic                last_pixel_o;

  // Shadow registers
  logic [1:0]  fmt_reg;
  logic        alpha_reg;
  logic [15:0] width_reg;
  logic [15:0] height_reg;
  logic [8:0]  entries_reg;

  // Predicted unpacker state
  logic [31:0] color_shadow [TableDepth];
  logic [23:0] gather;
  int unsigned byte_phase;
  int unsigned fill_cnt;
  int unsigned col_cnt;
  int unsigned row_cnt;

  pixel_t      expected_pixels [$];
  logic [7:0]  stream_q [$];
  int          mismatch_cnt = 0;
  int          cycle_cnt    = 0;
  int          stall_left   = 0;
  bit          calm         = 1'b0;

  lossless_bitmap_pixel_unpacker dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_argb_o (pixel_argb_o),
    .last_pixel_o (last_pixel_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Mostly no gap, some short ones, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void restart_image();
    gather     = '0;
    byte_phase = 0;
    fill_cnt   = 0;
    col_cnt    = 0;
    row_cnt    = 0;
  endfunction

  function automatic void reset_unpacker();
    fmt_reg     = FmtPalette;
    alpha_reg   = 1'b0;
    width_reg   = 16'd1;
    height_reg  = 16'd1;
    entries_reg = 9'd256;
    foreach (color_shadow[i]) color_shadow[i] = '0;
    restart_image();
  endfunction

  // One unit of a row that is 'units' long; only columns below the width
  // produce a pixel, the rest is padding
  function automatic void advance_pixel(input int unsigned units, input logic [31:0] px);
    int unsigned w, h;
    logic        is_last;
    w = (width_reg == 0) ? 1 : width_reg;
    h = (height_reg == 0) ? 1 : height_reg;
    if (col_cnt < w) begin
      is_last = (col_cnt >= w - 1) && (row_cnt >= h - 1);
      expected_pixels.push_back('{argb: px, last: is_last});
      if (is_last) begin
        // Final row padding is not consumed
        restart_image();
        return;
      end
    end
    if (col_cnt + 1 >= units) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1) & 32'hFFFF;
    end else begin
      col_cnt = (col_cnt + 1) & 32'hFFFF;
    end
  endfunction

  function automatic void unpack_byte(input logic [7:0] b);
    int unsigned cap, need, w, c, red, green, blue;
    logic [31:0] px;
    w = (width_reg == 0) ? 1 : width_reg;
    case (fmt_reg)
      FmtPalette: begin
        cap = (entries_reg > TableDepth) ? TableDepth : entries_reg;
        if (fill_cnt < cap) begin
          // Table load: RGB with opaque alpha, or RGBA
          need = alpha_reg ? 4 : 3;
          if (byte_phase + 1 >= need) begin
            if (alpha_reg) px = {b, gather};
            else px = {8'hFF, gather[15:0], b};
            color_shadow[fill_cnt % TableDepth] = px;
            fill_cnt++;
            gather     = '0;
            byte_phase = 0;
          end else begin
            gather     = {gather[15:0], b};
            byte_phase = (byte_phase + 1) & 3;
          end
        end else begin
          // Lookup; unloaded entries read as zero
          px = (b < fill_cnt) ? color_shadow[b] : 32'h0;
          advance_pixel((w + 3) & 32'hFFFF_FFFC, px);
        end
      end
      FmtRgb555: begin
        if (byte_phase == 0) begin
          gather     = {16'h0, b};
          byte_phase = 1;
        end else begin
          c          = {gather[7:0], b};
          gather     = '0;
          byte_phase = 0;
          blue  = ((c << 3) | ((c >> 2) & 32'h7)) & 32'hFF;
          green = ((c >> 2) & 32'hF8) | ((c >> 7) & 32'h7);
          red   = ((c >> 7) & 32'hF8) | ((c >> 12) & 32'h7);
          advance_pixel(w + (w & 1), {8'hFF, red[7:0], green[7:0], blue[7:0]});
        end
      end
      FmtXrgb32: begin
        if (byte_phase < 3) begin
          gather = {gather[15:0], b};
          byte_phase++;
        end else begin
          px         = {gather, b};
          gather     = '0;
          byte_phase = 0;
          advance_pixel(w, px);
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_pixel(input logic [31:0] argb, input logic last);
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      report_mismatch($sformatf("pixel %08h last %0b with none expected", argb, last));
      return;
    end
    want = expected_pixels.pop_front();
    if (argb !== want.argb)
      report_mismatch($sformatf("pixel_argb %08h, expected %08h", argb, want.argb));
    if (last !== want.last)
      report_mismatch($sformatf("last_pixel %0b, expected %0b (pixel %08h)",
                                last, want.last, want.argb));
  endtask

  // Pixel sink with random backpressure
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_pixel(pixel_argb_o, last_pixel_o);
    if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    out_stall_i <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Valid stays up across back-to-back requests; it drops only for a gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    unpack_byte(b);
  endtask

  task automatic send_stream();
    while (stream_q.size() != 0) send_byte(stream_q.pop_front());
  endtask

  // Drain all pixels, then let the pipeline settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Unused upper data bits sometimes carry junk
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value,
                           input logic [CfgDataW-1:0] keep);
    logic [CfgDataW-1:0] junk, data;
    junk = ($urandom_range(0, 3) == 0) ? CfgDataW'($urandom) : '0;
    data = (junk & ~keep) | (value & keep);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgFormat:  fmt_reg     = data[1:0];
      CfgAlpha:   alpha_reg   = data[0];
      CfgWidth:   width_reg   = data[15:0];
      CfgHeight:  height_reg  = data[15:0];
      CfgEntries: entries_reg = data[8:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [1:0] fmt, input logic alpha,
                                input logic [15:0] w, input logic [15:0] h,
                                input logic [8:0] entries);
    wait_idle();
    write_reg(CfgFormat, 16'(fmt), 16'h0003);
    write_reg(CfgAlpha, 16'(alpha), 16'h0001);
    write_reg(CfgWidth, w, 16'hFFFF);
    write_reg(CfgHeight, h, 16'hFFFF);
    write_reg(CfgEntries, 16'(entries), 16'h01FF);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Image generation
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_index(input int unsigned loads);
    if ($urandom_range(0, 4) == 0) return 8'($urandom);
    return 8'($urandom_range(0, (loads > 255) ? 255 : loads));
  endfunction

  // Well-formed image for the current settings, final row without padding
  function automatic void build_image();
    int w, h, loads, per_color, row_len;
    w = (width_reg == 0) ? 1 : width_reg;
    h = (height_reg == 0) ? 1 : height_reg;
    case (fmt_reg)
      FmtPalette: begin
        loads     = (entries_reg > TableDepth) ? TableDepth : entries_reg;
        per_color = alpha_reg ? 4 : 3;
        repeat (loads * per_color) stream_q.push_back(8'($urandom));
        for (int r = 0; r < h; r++) begin
          row_len = (r == h - 1) ? w : ((w + 3) & 32'hFFFF_FFFC);
          for (int c = 0; c < row_len; c++)
            stream_q.push_back((c < w) ? pick_index(loads) : 8'($urandom));
        end
      end
      FmtRgb555: begin
        for (int r = 0; r < h; r++) begin
          row_len = (r == h - 1) ? w : (w + (w & 1));
          repeat (2 * row_len) stream_q.push_back(8'($urandom));
        end
      end
      FmtXrgb32: repeat (4 * w * h) stream_q.push_back(8'($urandom));
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // RGBA table load, a hit and an unloaded index
  task automatic test_palette_lookup();
    apply_settings(FmtPalette, 1'b1, 16'd2, 16'd1, 9'd2);
    stream_q = '{8'hFF, 8'h00, 8'h80, 8'h00, 8'h01, 8'h02, 8'h03, 8'hFF,
                 8'h01, 8'h02};
    send_stream();
  endtask

  // Max channels, pad pair on a row of odd width, top bit set on the last pixel
  task automatic test_rgb555_expand();
    apply_settings(FmtRgb555, 1'b0, 16'd1, 16'd2, 9'd256);
    stream_q = '{8'h7F, 8'hFF, 8'h12, 8'h34, 8'h80, 8'h00};
    send_stream();
  endtask

  task automatic test_reserved_format();
    apply_settings(FmtReserved, 1'b0, 16'd1, 16'd1, 9'd1);
    stream_q = '{8'hA5};
    send_stream();
  endtask

  // Zero sizes, empty and oversized table, maximum geometry, then a
  // geometry change in the middle of an image
  task automatic test_register_extremes();
    apply_settings(FmtPalette, 1'b0, 16'd0, 16'd0, 9'd0);
    stream_q = '{8'hFF};
    send_stream();
    apply_settings(FmtXrgb32, 1'b1, 16'hFFFF, 16'hFFFF, 9'h1FF);
    stream_q = '{8'hFF, 8'h00, 8'hFF, 8'h00};
    send_stream();
    apply_settings(FmtXrgb32, 1'b1, 16'd1, 16'd1, 9'h1FF);
    stream_q = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78};
    send_stream();
  endtask

  task automatic test_random_images();
    int          sent, r, images;
    logic [1:0]  fmt;
    logic        alpha;
    logic [15:0] w, h;
    logic [8:0]  entries;
    sent = 0;
    while (sent < RandomBytes) begin
      r = $urandom_range(0, 19);
      fmt = (r == 0) ? FmtReserved : (r < 8) ? FmtPalette : (r < 14) ? FmtRgb555 : FmtXrgb32;
      alpha = 1'($urandom);
      r = $urandom_range(0, 9);
      w = (r == 0) ? 16'd0 : (r == 1) ? 16'($urandom_range(10, 40)) : 16'($urandom_range(1, 9));
      h = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
      r = $urandom_range(0, 24);
      entries = (r == 0) ? 9'd0 : (r == 1) ? 9'($urandom_range(200, 511))
                                           : 9'($urandom_range(1, 12));
      apply_settings(fmt, alpha, w, h, entries);
      calm = ($urandom_range(0, 5) == 0);
      if (fmt == FmtReserved) begin
        repeat ($urandom_range(1, 6)) stream_q.push_back(8'($urandom));
        send_stream();
      end else begin
        images = $urandom_range(1, 2);
        repeat (images) begin
          build_image();
          // A cut-short image leaves the counters mid-row for the next settings
          if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, stream_q.size())) void'(stream_q.pop_back());
          if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 5)) stream_q.push_back(8'($urandom));
          sent += stream_q.size();
          send_stream();
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    reset_unpacker();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_palette_lookup();
    test_rgb555_expand();
    test_reserved_format();
    test_register_extremes();
    test_random_images();
    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
